FILE: rtl/kdclp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kdclp_pkg
// Shared types and constants for the key debounce / long-press scanner.
// ---------------------------------------------------------------------------
package kdclp_pkg;

  localparam int NUM_KEYS_DEF = 8;
  localparam int LEVELS_W     = 8;
  localparam int KEY_IDX_W    = 3;
  localparam int HOLD_W       = 8;

  localparam logic [HOLD_W-1:0] HOLD_MAX         = 8'hFF;
  localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 8'd100;

  localparam logic ACT_CLICK = 1'b0;
  localparam logic ACT_LONG  = 1'b1;

  typedef enum logic [1:0] {
    PH_RELEASED      = 2'd0,
    PH_PRESS_CHECK   = 2'd1,
    PH_HELD          = 2'd2,
    PH_RELEASE_CHECK = 2'd3
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic event_hit;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/kdclp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kdclp_ctrl
// Scan sequencer: takes a request, walks the keys one per cycle, stops at
// the first confirmed release and stalls while the result slot is full.
// ---------------------------------------------------------------------------
module kdclp_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  kdclp_pkg::dp_status_t  status,
  output kdclp_pkg::ctrl_cmd_t   cmd
);
  import kdclp_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.event_hit) begin
          if (status.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.commit = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/kdclp_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// kdclp_dp
// Per-key phase and hold count storage, the single-key update, the
// threshold register and the result register.
// ---------------------------------------------------------------------------
module kdclp_dp #(
  parameter int NUM_KEYS = kdclp_pkg::NUM_KEYS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire [kdclp_pkg::LEVELS_W-1:0]      in_key_levels,
  input  wire                                cfg_we,
  input  wire [kdclp_pkg::HOLD_W-1:0]        cfg_wdata,
  input  kdclp_pkg::ctrl_cmd_t               cmd,
  output kdclp_pkg::dp_status_t              status,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [kdclp_pkg::KEY_IDX_W-1:0]    out_key_index,
  output logic                               out_event_kind
);
  import kdclp_pkg::*;

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

  logic [NUM_KEYS-1:0] levels_r;
  logic [IDX_W-1:0]    idx_r;
  logic [HOLD_W-1:0]   thresh_r;
  phase_t              phase_r [NUM_KEYS];
  logic [HOLD_W-1:0]   hold_r  [NUM_KEYS];

  logic                 out_valid_r;
  logic [KEY_IDX_W-1:0] key_index_r;
  logic                 action_r;

  phase_t            phase_cur;
  logic [HOLD_W-1:0] hold_cur;
  phase_t            phase_nxt;
  logic [HOLD_W-1:0] hold_nxt;
  logic              pressed;
  logic              hit;
  logic              act;

  assign phase_cur = phase_r[idx_r];
  assign hold_cur  = hold_r[idx_r];
  assign pressed   = levels_r[idx_r];
  assign act       = (hold_cur >= thresh_r) ? ACT_LONG : ACT_CLICK;

  always_comb begin
    phase_nxt = phase_cur;
    hold_nxt  = hold_cur;
    hit       = 1'b0;
    unique case (phase_cur)
      PH_RELEASED: begin
        if (pressed) phase_nxt = PH_PRESS_CHECK;
      end
      PH_PRESS_CHECK: begin
        if (pressed) begin
          phase_nxt = PH_HELD;
          hold_nxt  = '0;
        end else begin
          phase_nxt = PH_RELEASED;
        end
      end
      PH_HELD: begin
        if (hold_cur != HOLD_MAX) hold_nxt = hold_cur + HOLD_W'(1);
        if (!pressed) phase_nxt = PH_RELEASE_CHECK;
      end
      PH_RELEASE_CHECK: begin
        if (pressed) begin
          phase_nxt = PH_HELD;
        end else begin
          phase_nxt = PH_RELEASED;
          hit       = 1'b1;
        end
      end
    endcase
  end

  assign status.event_hit = hit;
  assign status.last      = (idx_r == LAST_IDX);
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) levels_r <= in_key_levels[NUM_KEYS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k] <= PH_RELEASED;
        hold_r[k]  <= '0;
      end
    end else if (cmd.commit) begin
      phase_r[idx_r] <= phase_nxt;
      hold_r[idx_r]  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && hit) begin
      key_index_r <= KEY_IDX_W'(idx_r);
      action_r    <= act;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_index  = key_index_r;
  assign out_event_kind = action_r;

endmodule
`default_nettype wire

FILE: rtl/key_debounce_click_long_press_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// key_debounce_click_long_press_top
// Debounced key scanner reporting click or long press on confirmed release.
// ---------------------------------------------------------------------------
// One request is one scan tick of key levels. The keys are visited one per
// cycle by a shared update unit; the scan ends early at the first confirmed
// release, whose event goes to a one-entry result register. A new tick is
// accepted as soon as the scan has ended, even while a result is still
// waiting; a scan that finds an event while the result register is full
// holds until it is taken. The long-press threshold resets to 100 and is to
// be written by the user through cfg_we / cfg_wdata only while no tick is in
// progress; the block itself does not enforce this.
module key_debounce_click_long_press_top #(
  parameter int NUM_KEYS = kdclp_pkg::NUM_KEYS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [kdclp_pkg::LEVELS_W-1:0]    in_key_levels,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [kdclp_pkg::KEY_IDX_W-1:0]  out_key_index,
  output logic                             out_event_kind,
  input  wire                              cfg_we,
  input  wire [kdclp_pkg::HOLD_W-1:0]      cfg_wdata
);
  import kdclp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  kdclp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kdclp_dp #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_key_levels  (in_key_levels),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_index  (out_key_index),
    .out_event_kind (out_event_kind)
  );

endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the key debounce / long-press scanner.
// ---------------------------------------------------------------------------
// A short table of scan ticks exercises confirmation, bounce and the scan
// stopping at the first event. Random ticks follow: per-key press and
// release spans with glitches and noise mixed in, one span forced past
// counter saturation. The threshold is rewritten between runs of ticks,
// covering 0 and 255. Every tick updates a local copy of the key phases
// and hold counts. The events that copy predicts are queued and compared
// in order with what the block reports. Both sides idle at random, and the
// result side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb;
  import kdclp_pkg::*;

  localparam int N_KEYS     = NUM_KEYS_DEF;
  localparam int SCAN_SLACK = 2 * (N_KEYS + 2);

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    logic                 act;
  } key_event_t;

  typedef struct packed {
    logic [LEVELS_W-1:0]  levels;
    logic                 typed;
    logic [KEY_IDX_W-1:0] key;
    logic                 act;
  } tick_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [LEVELS_W-1:0]  in_key_levels;
  logic                 out_valid;
  logic                 out_ready;
  logic [KEY_IDX_W-1:0] out_key_index;
  logic                 out_event_kind;
  logic                 cfg_we;
  logic [HOLD_W-1:0]    cfg_wdata;

  phase_t            key_ph [N_KEYS];
  logic [HOLD_W-1:0] hold_ct [N_KEYS];
  logic [HOLD_W-1:0] long_thr;

  logic              goal_lvl [N_KEYS];
  int                span_left [N_KEYS];

  key_event_t pending_events[$];
  int errors;
  int ticks_sent;
  int results_seen;
  int clicks;
  int longs;
  bit stall_done;

  key_debounce_click_long_press_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key_levels  (in_key_levels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_index  (out_key_index),
    .out_event_kind (out_event_kind),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic scan_tick(input logic [LEVELS_W-1:0] lv, output key_event_t ev);
    logic found;
    found = 1'b0;
    ev = '0;
    for (int k = 0; k < N_KEYS && !found; k++) begin
      case (key_ph[k])
        PH_RELEASED: begin
          if (lv[k]) key_ph[k] = PH_PRESS_CHECK;
        end
        PH_PRESS_CHECK: begin
          if (lv[k]) begin
            key_ph[k]  = PH_HELD;
            hold_ct[k] = '0;
          end else begin
            key_ph[k] = PH_RELEASED;
          end
        end
        PH_HELD: begin
          if (hold_ct[k] != HOLD_MAX) hold_ct[k] = hold_ct[k] + HOLD_W'(1);
          if (!lv[k]) key_ph[k] = PH_RELEASE_CHECK;
        end
        PH_RELEASE_CHECK: begin
          if (lv[k]) begin
            key_ph[k] = PH_HELD;
          end else begin
            key_ph[k] = PH_RELEASED;
            ev.key    = k[KEY_IDX_W-1:0];
            ev.act    = (hold_ct[k] >= long_thr) ? ACT_LONG : ACT_CLICK;
            found     = 1'b1;
          end
        end
      endcase
    end
    return found;
  endfunction

  function automatic logic [LEVELS_W-1:0] next_levels();
    logic [LEVELS_W-1:0] lv;
    int r;
    for (int k = 0; k < N_KEYS; k++) begin
      if (span_left[k] == 0) begin
        goal_lvl[k] = ~goal_lvl[k];
        r = $urandom_range(0, 31);
        if (r == 0) span_left[k] = $urandom_range(250, 300);
        else if (r < 5) span_left[k] = $urandom_range(90, 130);
        else span_left[k] = $urandom_range(1, 8);
      end
      span_left[k]--;
    end
    lv = '0;
    for (int k = 0; k < N_KEYS; k++) lv[k] = goal_lvl[k];
    r = $urandom_range(0, 19);
    if (r == 0) lv = LEVELS_W'($urandom_range(0, 255));
    else if (r < 3) lv[$urandom_range(0, LEVELS_W-1)] ^= 1'b1;
    return lv;
  endfunction

  // Offer one request; return at the negedge after it is taken, valid still high.
  task automatic push_tick(input logic [LEVELS_W-1:0] lv, input logic typed,
                           input key_event_t typed_ev);
    key_event_t ev;
    logic hit;
    if (ticks_sent < 400 || ticks_sent >= 550) begin
      while ($urandom_range(0, 99) < 15) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_key_levels <= lv;
    do @(posedge clk); while (!in_ready);
    hit = scan_tick(lv, ev);
    if (typed) pending_events.push_back(typed_ev);
    else if (hit) pending_events.push_back(ev);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic set_threshold(input logic [HOLD_W-1:0] thr);
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SCAN_SLACK) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    long_thr = thr;
  endtask

  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_event_kind == ACT_LONG) longs++;
      else clicks++;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event key %0d action %0d", $time, out_key_index,
                 out_event_kind);
      end else begin
        want = pending_events.pop_front();
        if (out_key_index !== want.key) begin
          errors++;
          $display("%0t: key index expected %0d actual %0d", $time, want.key,
                   out_key_index);
        end
        if (out_event_kind !== want.act) begin
          errors++;
          $display("%0t: action expected %0d actual %0d", $time, want.act,
                   out_event_kind);
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && results_seen >= 40) begin
        stall_done = 1'b1;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 80 && results_seen < 140) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin
    tick_row_t  rows [14];
    logic [HOLD_W-1:0] thr_list [6];
    int         n_ticks;
    int         forced;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_key_levels = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    errors        = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    clicks        = 0;
    longs         = 0;
    stall_done    = 1'b0;
    long_thr      = LONG_PRESS_RESET;
    for (int k = 0; k < N_KEYS; k++) begin
      key_ph[k]    = PH_RELEASED;
      hold_ct[k]   = '0;
      goal_lvl[k]  = 1'b0;
      span_left[k] = $urandom_range(0, 6);
    end

    rows = '{
      '{8'h00, 1'b0, 3'd0, ACT_CLICK},
      '{8'h01, 1'b0, 3'd0, ACT_CLICK},
      '{8'h01, 1'b0, 3'd0, ACT_CLICK},
      '{8'h00, 1'b0, 3'd0, ACT_CLICK},
      '{8'h00, 1'b1, 3'd0, ACT_CLICK},
      '{8'hFF, 1'b0, 3'd0, ACT_CLICK},
      '{8'h00, 1'b0, 3'd0, ACT_CLICK},
      '{8'hFF, 1'b0, 3'd0, ACT_CLICK},
      '{8'hFF, 1'b0, 3'd0, ACT_CLICK},
      '{8'h7F, 1'b0, 3'd0, ACT_CLICK},
      '{8'hFF, 1'b0, 3'd0, ACT_CLICK},
      '{8'h00, 1'b0, 3'd0, ACT_CLICK},
      '{8'h00, 1'b1, 3'd0, ACT_CLICK},
      '{8'h00, 1'b1, 3'd1, ACT_CLICK}
    };
    thr_list = '{8'd0, HOLD_MAX, 8'd1, LONG_PRESS_RESET,
                 8'($urandom_range(2, 40)), 8'($urandom_range(0, 255))};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) push_tick(rows[i].levels, rows[i].typed, {rows[i].key, rows[i].act});
    in_valid <= 1'b0;

    foreach (thr_list[p]) begin
      set_threshold(thr_list[p]);
      n_ticks = 100;
      if (thr_list[p] == HOLD_MAX) begin
        // hold the first key, visited on every tick, well past counter saturation
        forced = 0;
        goal_lvl[forced]  = 1'b1;
        span_left[forced] = $urandom_range(270, 300);
        n_ticks = 330;
      end
      repeat (n_ticks) push_tick(next_levels(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    while (pending_events.size() != 0) @(negedge clk);
    repeat (SCAN_SLACK) @(negedge clk);

    $display("Sent %0d scan ticks over %0d thresholds (0 and 255 included).", ticks_sent,
             $size(thr_list) + 1);
    $display("Checked %0d events: %0d clicks, %0d long presses.", results_seen, clicks,
             longs);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/kdclp_pkg.sv
rtl/kdclp_ctrl.sv
rtl/kdclp_dp.sv
rtl/key_debounce_click_long_press_top.sv
test/tb.sv
